// ----- hw/rtl/format_string_output_engine_core_defines.svh -----
// ---------------------------------------------------------------------------
// format_string_output_engine_core_defines
// Assertion macros for the format engine controller.
// ---------------------------------------------------------------------------
`ifndef FORMAT_STRING_OUTPUT_ENGINE_CORE_DEFINES_SVH
`define FORMAT_STRING_OUTPUT_ENGINE_CORE_DEFINES_SVH
// Implication checked on every edge outside reset.
`define FSOE_ASSERT_IMP(lbl, clk_s, rst_s, pre, post, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define FSOE_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error(msg);
`endif

// ----- hw/rtl/fsoe_pkg.sv -----
// ---------------------------------------------------------------------------
// fsoe_pkg
// Types and constants shared by the format engine controller and datapath.
// ---------------------------------------------------------------------------
package fsoe_pkg;

  // Parse mode kept between format bytes.
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_PCT   = 2'd1,
    MODE_ESC   = 2'd2,
    MODE_PCTL  = 2'd3
  } mode_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CONV = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

  // Kind of numeric conversion.
  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_OCT = 2'd1,
    RAD_HEX = 2'd2
  } radix_t;

  // A 64-bit magnitude of 2**63 needs 22 octal digits.
  localparam int MAX_DIGITS = 22;
  localparam int DIG_IDX_W  = 5;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;   // capture item and plan the prefix
    logic step;   // produce one more digit
    logic pop;    // one output byte leaves
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic conv;       // item needs a numeric conversion
    logic empty;      // no bytes left for this item
  } stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction

endpackage

// ----- hw/rtl/fsoe_datapath.sv -----
// ---------------------------------------------------------------------------
// fsoe_datapath
// Decodes one format byte, builds the prefix bytes and digit string, and
// serves the output bytes one at a time.
// ---------------------------------------------------------------------------
module fsoe_datapath #(
  parameter int INT_WIDTH  = 32,
  parameter int LONG_WIDTH = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  fsoe_pkg::cmd_t cmd,
  output fsoe_pkg::stat_t stat,
  input  logic [7:0]     fmt_char,
  input  logic [63:0]    arg_word,
  output logic [7:0]     out_char,
  output logic           char_valid,
  output logic           last_of_run,
  output logic           format_done
);
  import fsoe_pkg::*;

  mode_t              mode;
  logic [7:0]         pre [3];
  logic [1:0]         pre_cnt;
  logic [1:0]         pre_idx;
  logic               bare;
  logic               done;
  logic [63:0]        mag;
  radix_t             radix;
  logic               conv;
  logic [7:0]         digs [MAX_DIGITS];
  logic [DIG_IDX_W-1:0] dig_cnt;

  // Combinational decode of the incoming byte.
  mode_t       mode_n;
  logic [7:0]  p0, p1, p2;
  logic [1:0]  pc_n;
  logic        done_n, conv_n, neg_n;
  logic [63:0] mag_n;
  radix_t      rad_n;
  logic [63:0] imask, lmask, iv, lv;
  always_comb begin
    imask = 64'(({64{1'b1}}) >> (64 - INT_WIDTH));
    lmask = 64'(({64{1'b1}}) >> (64 - LONG_WIDTH));
    iv = arg_word & imask;
    lv = arg_word & lmask;
    mode_n = MODE_PLAIN;
    p0 = fmt_char; p1 = 8'h00; p2 = 8'h00;
    pc_n = 2'd0; done_n = 1'b0; conv_n = 1'b0; neg_n = 1'b0;
    mag_n = iv; rad_n = RAD_HEX;
    case (mode)
      MODE_PLAIN: begin
        if (fmt_char == 8'h00) done_n = 1'b1;
        else if (fmt_char == "%") mode_n = MODE_PCT;
        else if (fmt_char == "\\") mode_n = MODE_ESC;
        else pc_n = 2'd1;
      end
      MODE_PCT: begin
        case (fmt_char)
          8'h00: begin p0 = "%"; pc_n = 2'd1; done_n = 1'b1; end
          "c": begin p0 = arg_word[7:0]; pc_n = 2'd1; end
          "d": begin
            conv_n = 1'b1; rad_n = RAD_DEC;
            neg_n = iv[INT_WIDTH-1];
            mag_n = neg_n ? ((~iv + 64'd1) & imask) : iv;
            p0 = "-"; pc_n = {1'b0, neg_n};
          end
          "o": begin conv_n = 1'b1; rad_n = RAD_OCT; end
          "x": conv_n = 1'b1;
          "p": begin
            conv_n = 1'b1; mag_n = lv; p0 = "0"; p1 = "x"; pc_n = 2'd2;
          end
          "l": mode_n = MODE_PCTL;
          default: begin p0 = "%"; p1 = fmt_char; pc_n = 2'd2; end
        endcase
      end
      MODE_ESC: begin
        pc_n = 2'd1;
        case (fmt_char)
          8'h00: begin p0 = "\\"; done_n = 1'b1; end
          "n": p0 = 8'h0a;
          "r": p0 = 8'h0d;
          "t": p0 = 8'h09;
          default: p0 = fmt_char;
        endcase
      end
      default: begin
        case (fmt_char)
          8'h00: begin p0 = "%"; p1 = "l"; pc_n = 2'd2; done_n = 1'b1; end
          "d", "o": begin
            conv_n = 1'b1;
            rad_n = (fmt_char == "d") ? RAD_DEC : RAD_OCT;
            neg_n = lv[LONG_WIDTH-1];
            mag_n = neg_n ? ((~lv + 64'd1) & lmask) : lv;
            p0 = "-"; pc_n = {1'b0, neg_n};
          end
          "x": begin conv_n = 1'b1; mag_n = lv; end
          default: begin p0 = "%"; p1 = "l"; p2 = fmt_char; pc_n = 2'd3; end
        endcase
      end
    endcase
  end

  // One digit step: least significant digit and shrunken magnitude.
  // Division by ten is a shift-add reciprocal spread over three steps; the
  // first two register a partial sum in div_part.
  logic [3:0]  dig;
  logic [63:0] mag_q;
  logic [63:0] div_part;
  logic [1:0]  div_ph;
  logic [63:0] div_s1, div_s2, div_s3, div_q, div_r;
  always_comb begin
    div_s1 = (mag >> 1) + (mag >> 2);
    div_s1 = div_s1 + (div_s1 >> 4);
    div_s2 = div_part + (div_part >> 8);
    div_s2 = div_s2 + (div_s2 >> 16);
    div_s3 = div_part + (div_part >> 32);
    div_q  = div_s3 >> 3;
    div_r  = mag - ((div_q << 3) + (div_q << 1));
    case (radix)
      RAD_OCT: begin dig = {1'b0, mag[2:0]}; mag_q = mag >> 3; end
      RAD_HEX: begin dig = mag[3:0];         mag_q = mag >> 4; end
      default: begin
        // The estimate is at most one low; fix it with one compare.
        if (div_r >= 64'd10) begin
          mag_q = div_q + 64'd1;
          dig = 4'(div_r - 64'd10);
        end else begin
          mag_q = div_q;
          dig = div_r[3:0];
        end
      end
    endcase
  end

  // Item capture, digit generation and byte serving.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
      dig_cnt <= '0;
      pre_cnt <= '0;
      pre_idx <= '0;
      conv <= 1'b0;
      div_ph <= '0;
    end else if (cmd.load) begin
      mode <= mode_n;
      pre[0] <= p0; pre[1] <= p1; pre[2] <= p2;
      pre_cnt <= pc_n;
      pre_idx <= '0;
      done <= done_n;
      bare <= done_n && (pc_n == 2'd0);
      conv <= conv_n;
      mag <= mag_n;
      radix <= rad_n;
      dig_cnt <= '0;
      div_ph <= '0;
    end else if (cmd.step) begin
      if ((radix == RAD_DEC) && (div_ph == 2'd0)) begin
        div_part <= div_s1;
        div_ph <= 2'd1;
      end else if ((radix == RAD_DEC) && (div_ph == 2'd1)) begin
        div_part <= div_s2;
        div_ph <= 2'd2;
      end else begin
        digs[dig_cnt] <= digit_char(dig);
        dig_cnt <= dig_cnt + 1'b1;
        mag <= mag_q;
        div_ph <= '0;
        if (mag_q == 64'd0) conv <= 1'b0;
      end
    end else if (cmd.pop) begin
      if (pre_idx != pre_cnt) pre_idx <= pre_idx + 1'b1;
      else if (dig_cnt != '0) dig_cnt <= dig_cnt - 1'b1;
      else bare <= 1'b0;
    end
  end

  logic [1:0] left;
  always_comb begin
    left = 2'(pre_cnt - pre_idx);
    stat.conv = conv;
    stat.empty = (left == 2'd0) && (dig_cnt == '0) && !bare;
    char_valid = !bare || (left != 2'd0);
    out_char = (left != 2'd0) ? pre[pre_idx] :
               (dig_cnt != '0) ? digs[dig_cnt - 1'b1] : 8'h00;
    last_of_run = bare ||
                  ((left == 2'd1) && (dig_cnt == '0)) ||
                  ((left == 2'd0) && (dig_cnt == DIG_IDX_W'(1)));
    format_done = last_of_run && done;
  end

endmodule

// ----- hw/rtl/fsoe_ctrl.sv -----
// ---------------------------------------------------------------------------
// fsoe_ctrl
// Sequences capture, digit generation and output of one item.
// ---------------------------------------------------------------------------
`include "format_string_output_engine_core_defines.svh"
module fsoe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output fsoe_pkg::cmd_t  cmd,
  input  fsoe_pkg::stat_t stat
);
  import fsoe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.conv) cmd.step = 1'b1;
        else state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = !stat.empty;
        if (stat.empty) state_next = ST_IDLE;
        else if (!out_stall) cmd.pop = 1'b1;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `FSOE_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, in_stall, "accept while busy")
  `FSOE_ASSERT_IMP(a_out_only_emit, clk, rst, out_valid, state == ST_EMIT, "output outside emit")
  `FSOE_ASSERT_NEXT(a_load_to_conv, clk, rst, cmd.load, state == ST_CONV, "load not followed by conv")
endmodule

// ----- hw/rtl/format_string_output_engine_core.sv -----
// ---------------------------------------------------------------------------
// format_string_output_engine_core
// Printf-style format interpreter: one format byte in, text bytes out.
// ---------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid/in_stall   | fmt_char, arg_word
// output  | out       | out_valid/out_stall | out_char, char_valid,
//         |           |                     | last_of_run, format_done
// An item goes through a capture, digit generation (up to 22 digits), a step out
// of digit generation, output of its bytes (up to 23), and a return to idle.
// Digit generation uses one shift-add divide-by-ten unit, split into steps that
// hold a partial sum in div_part before each decimal digit is made.
// Reset returns the parser to plain text mode.
// Output stalls hold the current byte; no new item is taken until done.
module format_string_output_engine_core #(
  parameter int INT_WIDTH  = 32,
  parameter int LONG_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  fmt_char,
  input  logic [63:0] arg_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        char_valid,
  output logic        last_of_run,
  output logic        format_done
);
  import fsoe_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fsoe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  fsoe_datapath #(.INT_WIDTH(INT_WIDTH), .LONG_WIDTH(LONG_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .fmt_char(fmt_char), .arg_word(arg_word),
    .out_char(out_char), .char_valid(char_valid),
    .last_of_run(last_of_run), .format_done(format_done)
  );
endmodule

// ----- tb/tb_format_string_output_engine_core.sv -----
// ---------------------------------------------------------------------------
// tb_format_string_output_engine_core
// Self-checking bench for the printf-style format interpreter. A driver sends
// format bytes from a queue and a text predictor computes the expected output
// bytes. A monitor compares each output item field by field, in order.
// ---------------------------------------------------------------------------
module tb_format_string_output_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fsoe_pkg::*;

  localparam int INT_W  = 32;
  localparam int LONG_W = 64;

  typedef struct packed {
    logic [7:0]  ch;
    logic [63:0] arg;
  } fmt_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       last;
    logic       done;
  } text_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  fmt_char = 8'd0;
  logic [63:0] arg_word = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        last_of_run;
  logic        format_done;

  fmt_item_t  pending_fmt[$];
  text_item_t expected_text[$];
  mode_t      pred_mode;
  int         errors = 0;
  int         hold_gap = 0;
  bit         wait_drain = 1'b0;

  format_string_output_engine_core #(.INT_WIDTH(INT_W), .LONG_WIDTH(LONG_W)) dut (.*);

  always #2 clk = ~clk;

  // No gap half the time, otherwise mostly short gaps and sometimes long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void put_char(ref text_item_t q[$], input logic [7:0] c);
    text_item_t t;
    t.ch = c; t.cv = 1'b1; t.last = 1'b0; t.done = 1'b0;
    q.push_back(t);
  endfunction

  // Digits of a magnitude without leading zeros, minus sign first.
  function automatic void put_number(ref text_item_t q[$], input logic [63:0] mag,
                                     input int radix, input bit neg);
    logic [7:0] digs[$];
    logic [63:0] m;
    int d;
    m = mag;
    if (neg) put_char(q, "-");
    do begin
      d = int'(m % radix);
      digs.push_front(d < 10 ? 8'(48 + d) : 8'(87 + d));
      m = m / radix;
    end while (m != 0);
    foreach (digs[i]) put_char(q, digs[i]);
  endfunction

  // Text produced by one format byte; updates the predicted parse mode.
  task automatic predict_text(input fmt_item_t it);
    text_item_t q[$];
    text_item_t t;
    bit done;
    logic [31:0] iv;
    logic [31:0] ineg;
    logic [63:0] lv;
    done = 1'b0;
    iv = it.arg[31:0];
    ineg = -iv;
    lv = it.arg;
    case (pred_mode)
      MODE_PLAIN: begin
        if (it.ch == 8'd0) done = 1'b1;
        else if (it.ch == "%") pred_mode = MODE_PCT;
        else if (it.ch == "\\") pred_mode = MODE_ESC;
        else put_char(q, it.ch);
      end
      MODE_PCT: begin
        pred_mode = MODE_PLAIN;
        case (it.ch)
          8'd0: begin put_char(q, "%"); done = 1'b1; end
          "c": put_char(q, it.arg[7:0]);
          "d": put_number(q, iv[31] ? 64'(ineg) : 64'(iv), 10, iv[31]);
          "o": put_number(q, 64'(iv), 8, 1'b0);
          "x": put_number(q, 64'(iv), 16, 1'b0);
          "p": begin put_char(q, "0"); put_char(q, "x"); put_number(q, lv, 16, 1'b0); end
          "l": pred_mode = MODE_PCTL;
          default: begin put_char(q, "%"); put_char(q, it.ch); end
        endcase
      end
      MODE_ESC: begin
        pred_mode = MODE_PLAIN;
        if (it.ch == 8'd0) begin put_char(q, "\\"); done = 1'b1; end
        else if (it.ch == "n") put_char(q, 8'h0a);
        else if (it.ch == "r") put_char(q, 8'h0d);
        else if (it.ch == "t") put_char(q, 8'h09);
        else put_char(q, it.ch);
      end
      default: begin
        pred_mode = MODE_PLAIN;
        case (it.ch)
          8'd0: begin put_char(q, "%"); put_char(q, "l"); done = 1'b1; end
          "d": put_number(q, lv[63] ? -lv : lv, 10, lv[63]);
          "o": put_number(q, lv[63] ? -lv : lv, 8, lv[63]);
          "x": put_number(q, lv, 16, 1'b0);
          default: begin put_char(q, "%"); put_char(q, "l"); put_char(q, it.ch); end
        endcase
      end
    endcase
    if (done && q.size() == 0) begin
      t = '0;
      q.push_back(t);
    end
    if (q.size() > 0) begin
      q[q.size()-1].last = 1'b1;
      q[q.size()-1].done = done;
    end
    foreach (q[i]) expected_text.push_back(q[i]);
  endtask

  function automatic fmt_item_t mk(input logic [7:0] c, input logic [63:0] a);
    fmt_item_t it;
    it.ch = c; it.arg = a;
    return it;
  endfunction

  function automatic logic [63:0] rand_arg();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return {$urandom, $urandom} >> $urandom_range(0, 63);
      2: return {32'hffff_ffff, $urandom};
      3: return {$urandom, 32'h8000_0000};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Random format token: mostly conversions and escapes, some malformed.
  task automatic add_random_token();
    byte unsigned conv[] = '{"c", "d", "o", "x", "p", "%", "s", "f"};
    byte unsigned lconv[] = '{"d", "o", "x", "q"};
    byte unsigned esc[] = '{"n", "r", "t", "\\", "a"};
    case ($urandom_range(0, 9))
      0, 1: pending_fmt.push_back(mk(8'($urandom_range(1, 255)), rand_arg()));
      2, 3, 4: begin
        pending_fmt.push_back(mk("%", rand_arg()));
        pending_fmt.push_back(mk(conv[$urandom_range(0, 7)], rand_arg()));
      end
      5, 6: begin
        pending_fmt.push_back(mk("%", rand_arg()));
        pending_fmt.push_back(mk("l", rand_arg()));
        pending_fmt.push_back(mk(lconv[$urandom_range(0, 3)], rand_arg()));
      end
      7: begin
        pending_fmt.push_back(mk("\\", rand_arg()));
        pending_fmt.push_back(mk(esc[$urandom_range(0, 4)], rand_arg()));
      end
      8: pending_fmt.push_back(mk(8'd0, rand_arg()));
      default: pending_fmt.push_back(mk(8'($urandom_range(0, 255)), rand_arg()));
    endcase
  endtask

  // Driver: presents queued format bytes with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      predict_text(mk(fmt_char, arg_word));
      hold_gap = pick_gap();
      in_valid <= 1'b0;
    end else if (!in_valid) begin
      if (hold_gap > 0) begin
        hold_gap--;
      end else if (wait_drain) begin
        if (expected_text.size() == 0) wait_drain = 1'b0;
      end else if (pending_fmt.size() > 0) begin
        fmt_char <= pending_fmt[0].ch;
        arg_word <= pending_fmt[0].arg;
        pending_fmt.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Monitor: checks each output item and randomizes the stall.
  always @(posedge clk) begin
    text_item_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          $error("unexpected output item out_char=%h", out_char);
          errors++;
        end else begin
          e = expected_text.pop_front();
          if (out_char !== e.ch) begin
            $error("out_char expected %h actual %h", e.ch, out_char); errors++;
          end
          if (char_valid !== e.cv) begin
            $error("char_valid expected %b actual %b", e.cv, char_valid); errors++;
          end
          if (last_of_run !== e.last) begin
            $error("last_of_run expected %b actual %b", e.last, last_of_run); errors++;
          end
          if (format_done !== e.done) begin
            $error("format_done expected %b actual %b", e.done, format_done); errors++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
    end
  end

  // Stimulus and end of run.
  initial begin
    pred_mode = MODE_PLAIN;
    // Directed: plain text, escapes, each conversion but %lx, and field extremes.
    pending_fmt.push_back(mk("A", 64'd0));
    pending_fmt.push_back(mk(8'hff, '1));
    pending_fmt.push_back(mk("\\", 64'd0));
    pending_fmt.push_back(mk("n", 64'd0));
    pending_fmt.push_back(mk("\\", 64'd0));
    pending_fmt.push_back(mk("r", 64'd0));
    pending_fmt.push_back(mk("\\", 64'd0));
    pending_fmt.push_back(mk("t", 64'd0));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("c", 64'hffff_ffff_ffff_ff41));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("d", 64'h0000_0000_8000_0000));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("o", '1));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("x", 64'd0));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("p", '1));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("l", 64'd0));
    pending_fmt.push_back(mk("d", 64'h8000_0000_0000_0000));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("l", 64'd0));
    pending_fmt.push_back(mk("o", '1));
    pending_fmt.push_back(mk(8'd0, 64'd0));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Pause the sender once until the directed text has all come out.
    wait (pending_fmt.size() == 0);
    wait_drain = 1'b1;
    // Endings after each pending prefix, then %lx of all ones and random tokens.
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk(8'd0, 64'd0));
    pending_fmt.push_back(mk("\\", 64'd0));
    pending_fmt.push_back(mk(8'd0, 64'd0));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("l", 64'd0));
    pending_fmt.push_back(mk(8'd0, 64'd0));
    pending_fmt.push_back(mk("%", 64'd0));
    pending_fmt.push_back(mk("l", 64'd0));
    pending_fmt.push_back(mk("x", '1));
    for (int i = 0; i < 95; i++) add_random_token();
    wait (pending_fmt.size() == 0 && !in_valid && expected_text.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_text.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fsoe_pkg.sv
hw/rtl/fsoe_datapath.sv
hw/rtl/fsoe_ctrl.sv
hw/rtl/format_string_output_engine_core.sv
tb/tb_format_string_output_engine_core.sv
